/* hdl/vvds_pkg.sv */
// ----------------------------------------------------------------------------
// vvds_pkg: shared types and helpers
// Body and result words, register indexes, 32-bit clip helper.
// ----------------------------------------------------------------------------
package vvds_pkg;

	typedef struct packed {
		logic [15:0]        object_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic [31:0]        mass;
		logic [31:0]        drag;
		logic               is_enemy;
	} body_word_t;

	typedef struct packed {
		logic [15:0]        result_id;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic               mass_zero;
		logic               saturated;
	} result_word_t;

	typedef enum logic [1:0] {
		REG_TIME_STEP   = 2'd0,
		REG_ENEMY_BOUND = 2'd1,
		REG_ENEMY_SPEED = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic               clip;
		logic signed [31:0] val;
	} sat_t;

	// clip a wide signed value to the int32 range
	function automatic sat_t sat32(input logic signed [64:0] v);
		sat_t r;
		if (v > 65'sd2147483647) begin
			r.clip = 1'b1;
			r.val  = 32'sh7fffffff;
		end else if (v < -65'sd2147483648) begin
			r.clip = 1'b1;
			r.val  = 32'sh80000000;
		end else begin
			r.clip = 1'b0;
			r.val  = v[31:0];
		end
		return r;
	endfunction

endpackage

/* hdl/velocity_verlet_drag_step.sv */
// ----------------------------------------------------------------------------
// velocity_verlet_drag_step: one Verlet step with linear drag per body
// Path from start to done: divider stages, stages s1 to s6, output register.
// Throughput: one body per cycle; busy is always low, the receiver cannot
// stall, so the pipeline never holds. Set by the one-bit-per-stage divider.
// Reset: async active low clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module velocity_verlet_drag_step
	import vvds_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// body channel
	input  logic         start,
	output logic         busy,
	input  body_word_t   body,
	// result channel, one cycle strobe
	output logic         done,
	output result_word_t result,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int DW = 32 + FRAC_BITS;

	// ---------------- configuration ----------------
	logic [31:0] time_step_q;
	logic [30:0] enemy_bound_q;
	logic [30:0] enemy_speed_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= 32'd1092;
			enemy_bound_q <= 31'(245 << FRAC_BITS);
			enemy_speed_q <= 31'(1 << (FRAC_BITS - 1));
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_TIME_STEP:   time_step_q   <= cfg_data;
				REG_ENEMY_BOUND: enemy_bound_q <= cfg_data[30:0];
				REG_ENEMY_SPEED: enemy_speed_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic signed [32:0] dt_s, half_s;
	assign dt_s   = $signed({1'b0, time_step_q});
	assign half_s = $signed({2'b0, time_step_q[31:1]});

	// ---------------- divide |F| << FRAC_BITS by mass ----------------
	logic          take;
	logic [31:0]   mag_x, mag_y;
	logic          dvx_valid, dvy_valid;
	logic [DW-1:0] qx, qy;

	assign take  = start & ~busy;
	assign mag_x = body.force_x[31] ? 32'(-body.force_x) : body.force_x;
	assign mag_y = body.force_y[31] ? 32'(-body.force_y) : body.force_y;

	vvds_div #(.DW(DW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .in_valid(take),
		.dividend({mag_x, {FRAC_BITS{1'b0}}}), .divisor(body.mass),
		.out_valid(dvx_valid), .quotient(qx)
	);

	vvds_div #(.DW(DW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .in_valid(take),
		.dividend({mag_y, {FRAC_BITS{1'b0}}}), .divisor(body.mass),
		.out_valid(dvy_valid), .quotient(qy)
	);

	// body word rides alongside the divider
	body_word_t pl_d [0:DW];
	assign pl_d[0] = body;
	for (genvar i = 0; i < DW; i++) begin : g_dly
		always_ff @(posedge clk) pl_d[i+1] <= pl_d[i];
	end

	// ---------------- post-divide stages ----------------
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	body_word_t         pl_s1, pl_s2, pl_s3, pl_s4, pl_s5, pl_s6;
	logic               sat_s1, sat_s2, sat_s3, sat_s4, sat_s5, sat_s6;
	logic signed [31:0] ax_s1, ay_s1;
	logic signed [64:0] hxp_s2, hyp_s2;
	logic [63:0]        ddp_s2;
	logic signed [31:0] hx_s3, hy_s3, k_s3, k_s4, k_s5;
	logic signed [31:0] hx_s4, hy_s4, tvx_s4, tvy_s4;
	logic signed [64:0] ptxp_s5, ptyp_s5, vkxp_s6, vkyp_s6;
	logic signed [31:0] v1x_s5, v1y_s5, ptx_s6, pty_s6;

	// stage 1: signed acceleration
	sat_t               ax_c, ay_c;
	logic               mz_d;
	always_comb begin
		mz_d = pl_d[DW].mass == 32'd0;
		ax_c = sat32(pl_d[DW].force_x[31] ? -$signed({{(65-DW){1'b0}}, qx})
		                                   :  $signed({{(65-DW){1'b0}}, qx}));
		ay_c = sat32(pl_d[DW].force_y[31] ? -$signed({{(65-DW){1'b0}}, qy})
		                                   :  $signed({{(65-DW){1'b0}}, qy}));
		if (mz_d) begin
			ax_c = '0;
			ay_c = '0;
		end
	end

	// stage 3: half-step velocity delta and drag factor
	sat_t hx_c, hy_c, k_c;
	always_comb begin
		hx_c = sat32(hxp_s2 >>> FRAC_BITS);
		hy_c = sat32(hyp_s2 >>> FRAC_BITS);
		k_c  = sat32($signed({1'b0, 64'(64'd1 << FRAC_BITS)})
		           - $signed({1'b0, 64'(ddp_s2 >> FRAC_BITS)}));
	end

	// stage 4 / 5 / 6 clip points
	sat_t tvx_c, tvy_c, v1x_c, v1y_c, ptx_c, pty_c;
	always_comb begin
		tvx_c = sat32(65'(pl_s3.vel_x) + 65'(hx_s3));
		tvy_c = sat32(65'(pl_s3.vel_y) + 65'(hy_s3));
		v1x_c = sat32(65'(tvx_s4) + 65'(hx_s4));
		v1y_c = sat32(65'(tvy_s4) + 65'(hy_s4));
		ptx_c = sat32(ptxp_s5 >>> FRAC_BITS);
		pty_c = sat32(ptyp_s5 >>> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			v_s1 <= dvx_valid & dvy_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// s1
		pl_s1  <= pl_d[DW];
		ax_s1  <= ax_c.val;
		ay_s1  <= ay_c.val;
		sat_s1 <= ax_c.clip | ay_c.clip;
		// s2: products a*dt/2 and drag*dt
		pl_s2  <= pl_s1;
		sat_s2 <= sat_s1;
		hxp_s2 <= 65'(ax_s1) * 65'(half_s);
		hyp_s2 <= 65'(ay_s1) * 65'(half_s);
		ddp_s2 <= 64'(pl_s1.drag) * 64'(time_step_q);
		// s3
		pl_s3  <= pl_s2;
		hx_s3  <= hx_c.val;
		hy_s3  <= hy_c.val;
		k_s3   <= k_c.val;
		sat_s3 <= sat_s2 | hx_c.clip | hy_c.clip | k_c.clip;
		// s4: half-step velocity
		pl_s4  <= pl_s3;
		hx_s4  <= hx_s3;
		hy_s4  <= hy_s3;
		k_s4   <= k_s3;
		tvx_s4 <= tvx_c.val;
		tvy_s4 <= tvy_c.val;
		sat_s4 <= sat_s3 | tvx_c.clip | tvy_c.clip;
		// s5: tv*dt, full-step velocity
		pl_s5   <= pl_s4;
		k_s5    <= k_s4;
		ptxp_s5 <= 65'(tvx_s4) * 65'(dt_s);
		ptyp_s5 <= 65'(tvy_s4) * 65'(dt_s);
		v1x_s5  <= v1x_c.val;
		v1y_s5  <= v1y_c.val;
		sat_s5  <= sat_s4 | v1x_c.clip | v1y_c.clip;
		// s6: position delta, drag product
		pl_s6   <= pl_s5;
		ptx_s6  <= ptx_c.val;
		pty_s6  <= pty_c.val;
		vkxp_s6 <= 65'(v1x_s5) * 65'(k_s5);
		vkyp_s6 <= 65'(v1y_s5) * 65'(k_s5);
		sat_s6  <= sat_s5 | ptx_c.clip | pty_c.clip;
	end

	// ---------------- output stage: position, drag, enemy rule ----------------
	sat_t               npx_c, npy_c, vx_c, vy_c;
	logic signed [31:0] vx_o, vy_o;
	logic signed [32:0] bnd;
	always_comb begin
		npx_c = sat32(65'(pl_s6.pos_x) + 65'(ptx_s6));
		npy_c = sat32(65'(pl_s6.pos_y) + 65'(pty_s6));
		vx_c  = sat32(vkxp_s6 >>> FRAC_BITS);
		vy_c  = sat32(vkyp_s6 >>> FRAC_BITS);
		bnd   = $signed({2'b0, enemy_bound_q});
		vx_o  = vx_c.val;
		vy_o  = vy_c.val;
		if (pl_s6.is_enemy) begin
			// pre-update Y against the bound; lower bound wins on a tie
			if (33'(pl_s6.pos_y) >= bnd) begin
				vx_o = '0;
				vy_o = -$signed({1'b0, enemy_speed_q});
			end
			if (33'(pl_s6.pos_y) <= -bnd) begin
				vx_o = '0;
				vy_o = $signed({1'b0, enemy_speed_q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		result.result_id <= pl_s6.object_id;
		result.new_pos_x <= npx_c.val;
		result.new_pos_y <= npy_c.val;
		result.new_vel_x <= vx_o;
		result.new_vel_y <= vy_o;
		result.mass_zero <= pl_s6.mass == 32'd0;
		result.saturated <= sat_s6 | npx_c.clip | npy_c.clip | vx_c.clip | vy_c.clip;
	end

endmodule

/* hdl/vvds_div.sv */
// ----------------------------------------------------------------------------
// vvds_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage; takes a new word each cycle.
// ----------------------------------------------------------------------------
module vvds_div #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          out_valid,
	output logic [DW-1:0] quotient
);

	logic          vld [0:DW];
	logic [31:0]   rem [0:DW];
	logic [DW-1:0] dq  [0:DW];
	logic [31:0]   dv  [0:DW];

	assign vld[0] = in_valid;
	assign rem[0] = '0;
	assign dq[0]  = dividend;
	assign dv[0]  = divisor;

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic [32:0] trial;
		logic        ge;
		logic [32:0] diff;

		always_comb begin
			trial = {rem[i], dq[i][DW-1]};
			diff  = trial - {1'b0, dv[i]};
			ge    = trial >= {1'b0, dv[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			rem[i+1] <= ge ? diff[31:0] : trial[31:0];
			dq[i+1]  <= {dq[i][DW-2:0], ge};
			dv[i+1]  <= dv[i];
		end
	end

	assign out_valid = vld[DW];
	assign quotient  = dq[DW];

endmodule
